@@ rtl/etf_pkg.sv @@
// ----------------------------------------------------------------------------
// etf_pkg
// Shared types, constants and CRC helpers for the Ethernet transmit framer.
// ----------------------------------------------------------------------------
package etf_pkg;

	localparam logic [11:0] MAX_FRAME = 12'd2048;
	localparam logic [11:0] MIN_LEN   = 12'd60;
	localparam logic [11:0] HDR_LEN   = 12'd8;
	localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
	localparam logic [7:0]  PRE_BYTE  = 8'h55;
	localparam logic [7:0]  SFD_BYTE  = 8'h5d;
	localparam logic [3:0]  NIB_MASK  = 4'hf;
	localparam logic [2:0]  PRE_LAST  = 3'd7;
	localparam logic [1:0]  CRC_LAST  = 2'd3;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_DATA  = 2'd1,
		FUNC_END   = 2'd2,
		FUNC_BAD   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		OP_START,
		OP_DATA,
		OP_END,
		OP_BAD
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRE,
		ST_PAD,
		ST_CRC
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] rev8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7 - i];
		end
		return r;
	endfunction

	function automatic logic [3:0] rev4(input logic [3:0] b);
		return {b[0], b[1], b[2], b[3]};
	endfunction

	// reflected-input crc-32, one byte
	function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {rev8(b), 24'h0};
		for (int i = 0; i < 8; i++) begin
			c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [7:0] crc_out_byte(input logic [7:0] b);
		return {rev4(b[7:4] ^ NIB_MASK), rev4(b[3:0] ^ NIB_MASK)};
	endfunction

endpackage

@@ rtl/etf_front.sv @@
// ----------------------------------------------------------------------------
// etf_front
// Input stage: takes a transaction, decodes the selector into a command and
// pushes it into the command queue.
// ----------------------------------------------------------------------------
module etf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           func,
	input  logic [7:0]           data_byte,
	input  etf_pkg::q_status_t   q_stat,
	output logic                 push,
	output etf_pkg::cmd_t        push_cmd
);

	logic          valid_s1;
	etf_pkg::cmd_t cmd_s1;
	etf_pkg::op_t  op_dec;
	logic          accept;

	always_comb begin
		case (func)
			etf_pkg::FUNC_START: op_dec = etf_pkg::OP_START;
			etf_pkg::FUNC_DATA:  op_dec = etf_pkg::OP_DATA;
			etf_pkg::FUNC_END:   op_dec = etf_pkg::OP_END;
			default:             op_dec = etf_pkg::OP_BAD;
		endcase
	end

	assign in_stall = valid_s1 & q_stat.full;
	assign accept   = in_valid & ~in_stall;
	assign push     = valid_s1 & ~q_stat.full;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept | (valid_s1 & q_stat.full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op   <= op_dec;
			cmd_s1.data <= data_byte;
		end
	end

endmodule

@@ rtl/etf_queue.sv @@
// ----------------------------------------------------------------------------
// etf_queue
// Small command queue between the decode front and the framing back end.
// ----------------------------------------------------------------------------
module etf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  etf_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output etf_pkg::cmd_t      pop_cmd,
	output etf_pkg::q_status_t q_stat
);

	etf_pkg::cmd_t              entry_q [etf_pkg::Q_DEPTH];
	logic [etf_pkg::Q_AW-1:0]   wr_ptr_q;
	logic [etf_pkg::Q_AW-1:0]   rd_ptr_q;
	logic [etf_pkg::Q_AW:0]     count_q;
	logic                       do_push;
	logic                       do_pop;

	assign q_stat.full  = (count_q == (etf_pkg::Q_AW+1)'(etf_pkg::Q_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push & ~q_stat.full;
	assign do_pop       = pop & ~q_stat.empty;
	assign pop_cmd      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ rtl/etf_back.sv @@
// ----------------------------------------------------------------------------
// etf_back
// Framing sequencer: preamble, payload with crc-32 update, zero padding and
// crc trailer, one result byte per unstalled cycle into an output register.
// ----------------------------------------------------------------------------
module etf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  etf_pkg::q_status_t q_stat,
	input  etf_pkg::cmd_t      pop_cmd,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic [11:0]        byte_offset,
	output logic               last,
	output logic [9:0]         word_count,
	output logic               error
);

	etf_pkg::state_t st_q, st_d;
	logic [31:0]     crc_q, crc_d;
	logic [11:0]     pay_q, pay_d;
	logic            open_q, open_d;
	logic [2:0]      cnt_q, cnt_d;

	logic            go;
	logic            need_pad;
	logic [1:0]      crc_idx;
	logic [7:0]      crc_sel;
	logic [12:0]     words_sum;
	logic [11:0]     pay_off;

	logic            r_valid;
	logic [7:0]      r_byte;
	logic [11:0]     r_off;
	logic            r_last;
	logic [9:0]      r_words;
	logic            r_err;

	logic            ovalid_q;

	assign go        = ~ovalid_q | ~out_stall;
	assign need_pad  = (pay_q < etf_pkg::MIN_LEN) || (pay_q[1:0] != 2'd0);
	assign crc_idx   = (st_q == etf_pkg::ST_CRC) ? cnt_q[1:0] : 2'd0;
	assign crc_sel   = crc_q[{~crc_idx, 3'b000} +: 8];
	assign words_sum = {1'b0, pay_q} + 13'd16;
	assign pay_off   = pay_q + etf_pkg::HDR_LEN;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			etf_pkg::ST_IDLE: begin
				if (go && !q_stat.empty) begin
					if (pop_cmd.op == etf_pkg::OP_START) begin
						st_d = etf_pkg::ST_PRE;
					end else if (pop_cmd.op == etf_pkg::OP_END && open_q) begin
						st_d = etf_pkg::ST_PAD;
					end
				end
			end
			etf_pkg::ST_PRE: begin
				if (go && cnt_q == etf_pkg::PRE_LAST) begin
					st_d = etf_pkg::ST_IDLE;
				end
			end
			etf_pkg::ST_PAD: begin
				if (go && !need_pad) begin
					st_d = etf_pkg::ST_CRC;
				end
			end
			etf_pkg::ST_CRC: begin
				if (go && cnt_q[1:0] == etf_pkg::CRC_LAST) begin
					st_d = etf_pkg::ST_IDLE;
				end
			end
			default: st_d = etf_pkg::ST_IDLE;
		endcase
	end

	// outputs and datapath
	always_comb begin
		pop     = 1'b0;
		r_valid = 1'b0;
		r_byte  = '0;
		r_off   = '0;
		r_last  = 1'b0;
		r_words = '0;
		r_err   = 1'b0;
		crc_d   = crc_q;
		pay_d   = pay_q;
		open_d  = open_q;
		cnt_d   = cnt_q;
		if (go) begin
			case (st_q)
				etf_pkg::ST_IDLE: begin
					if (!q_stat.empty) begin
						pop = 1'b1;
						case (pop_cmd.op)
							etf_pkg::OP_START: begin
								r_valid = 1'b1;
								r_byte  = etf_pkg::PRE_BYTE;
								cnt_d   = 3'd1;
								crc_d   = etf_pkg::CRC_INIT;
								pay_d   = '0;
								open_d  = 1'b1;
							end
							etf_pkg::OP_DATA: begin
								r_valid = 1'b1;
								if (!open_q || pay_q >= etf_pkg::MAX_FRAME) begin
									r_err = 1'b1;
								end else begin
									r_byte = {pop_cmd.data[3:0], pop_cmd.data[7:4]};
									r_off  = pay_off;
									crc_d  = etf_pkg::crc_feed(crc_q, pop_cmd.data);
									pay_d  = pay_q + 12'd1;
								end
							end
							etf_pkg::OP_END: begin
								// open frame goes on to padding with no result now
								if (!open_q) begin
									r_valid = 1'b1;
									r_err   = 1'b1;
								end
							end
							default: begin
								r_valid = 1'b1;
								r_err   = 1'b1;
							end
						endcase
					end
				end
				etf_pkg::ST_PRE: begin
					r_valid = 1'b1;
					r_off   = {9'd0, cnt_q};
					r_byte  = (cnt_q == etf_pkg::PRE_LAST) ? etf_pkg::SFD_BYTE
					                                       : etf_pkg::PRE_BYTE;
					cnt_d   = cnt_q + 3'd1;
				end
				etf_pkg::ST_PAD: begin
					r_valid = 1'b1;
					r_off   = pay_off;
					if (need_pad) begin
						crc_d = etf_pkg::crc_feed(crc_q, 8'd0);
						pay_d = pay_q + 12'd1;
					end else begin
						r_byte = etf_pkg::crc_out_byte(crc_sel);
						cnt_d  = 3'd1;
					end
				end
				etf_pkg::ST_CRC: begin
					r_valid = 1'b1;
					r_byte  = etf_pkg::crc_out_byte(crc_sel);
					r_off   = pay_off + {10'd0, cnt_q[1:0]};
					cnt_d   = cnt_q + 3'd1;
					if (cnt_q[1:0] == etf_pkg::CRC_LAST) begin
						r_last  = 1'b1;
						r_words = words_sum[11:2];
						open_d  = 1'b0;
					end
				end
				default: begin
					r_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= etf_pkg::ST_IDLE;
			crc_q    <= etf_pkg::CRC_INIT;
			pay_q    <= '0;
			open_q   <= 1'b0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			crc_q  <= crc_d;
			pay_q  <= pay_d;
			open_q <= open_d;
			cnt_q  <= cnt_d;
			if (go) begin
				ovalid_q <= r_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_byte    <= r_byte;
			byte_offset <= r_off;
			last        <= r_last;
			word_count  <= r_words;
			error       <= r_err;
		end
	end

	assign out_valid = ovalid_q;

endmodule

@@ rtl/ethernet_tx_framer_crc32_top.sv @@
// ----------------------------------------------------------------------------
// ethernet_tx_framer_crc32_top
// Ethernet transmit framer building a nibble-ordered buffer with crc-32.
// ----------------------------------------------------------------------------
// Each input transaction is decoded and queued (four entries), and the back
// end turns it into result bytes at one per cycle while out_stall is low.
// A data transaction or an error gives one result. A start gives eight
// preamble results. An end on an open frame gives no result at first, then
// one result per padding byte (up to 60 for a short frame) and four results
// for the crc trailer. The crc is updated a full byte per cycle, so the
// framing sequencer sets the rate: one result byte per clock.
module ethernet_tx_framer_crc32_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [11:0] byte_offset,
	output logic        last,
	output logic [9:0]  word_count,
	output logic        error
);

	etf_pkg::q_status_t q_stat;
	etf_pkg::cmd_t      push_cmd;
	etf_pkg::cmd_t      pop_cmd;
	logic               push;
	logic               pop;

	etf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.data_byte (data_byte),
		.q_stat    (q_stat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	etf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_stat   (q_stat)
	);

	etf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.pop_cmd     (pop_cmd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.byte_offset (byte_offset),
		.last        (last),
		.word_count  (word_count),
		.error       (error)
	);

	a_last_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> !error)
		else $error("last result flagged as error");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> out_byte == 8'd0 && byte_offset == 12'd0 && word_count == 10'd0)
		else $error("error result carries nonzero fields");

	a_words_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> word_count == 10'd0)
		else $error("word count outside last result");

	// last crc byte sits at padded length + 11, word count follows from it
	a_last_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> byte_offset[1:0] == 2'd3
			&& word_count == 10'((13'(byte_offset) + 13'd5) >> 2))
		else $error("last result offset and word count disagree");

endmodule

@@ sim/ethernet_tx_framer_crc32_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ethernet_tx_framer_crc32_top_test
// Self-checking bench for the Ethernet transmit framer. Start, data, end and
// illegal transactions are queued up front and driven with random gaps while
// the result side stalls at random. A behavioral frame model predicts every
// buffer byte (preamble, swapped payload, padding, crc trailer, errors) and
// the monitor checks each result against the oldest prediction.
// ----------------------------------------------------------------------------
module ethernet_tx_framer_crc32_top_test;

	typedef struct {
		etf_pkg::func_t op;
		logic [7:0]     data;
		bit             hold;
		int unsigned    gap_pct;
		int unsigned    stall_pct;
	} tx_item_t;

	typedef struct packed {
		logic [7:0]  val;
		logic [11:0] offset;
		logic        last;
		logic [9:0]  words;
		logic        err;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = etf_pkg::FUNC_START;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic [11:0] byte_offset;
	logic        last;
	logic [9:0]  word_count;
	logic        error;

	tx_item_t      pending_items[$];
	frame_result_t frame_bytes_due[$];

	int unsigned fill_gap_pct = 0;
	int unsigned fill_stall_pct = 0;
	int unsigned cur_stall_pct = 0;

	// frame model state
	logic [31:0] model_crc = etf_pkg::CRC_INIT;
	logic [11:0] model_len = '0;
	logic        model_open = 1'b0;

	int mismatches = 0;
	int items_taken = 0;
	int results_checked = 0;
	int frames_closed = 0;
	int error_results = 0;

	ethernet_tx_framer_crc32_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.byte_offset (byte_offset),
		.last        (last),
		.word_count  (word_count),
		.error       (error)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// crc-32 with reflected input, data bit injected as it reaches the top
	function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[31] ^ b[i];
			c = {c[30:0], 1'b0} ^ (fb ? etf_pkg::CRC_POLY : 32'h0);
		end
		return c;
	endfunction

	function automatic void queue_result(logic [7:0] v, logic [11:0] off, logic lst,
			logic [9:0] w, logic e);
		frame_result_t r;
		r.val = v;
		r.offset = off;
		r.last = lst;
		r.words = w;
		r.err = e;
		frame_bytes_due.push_back(r);
	endfunction

	function automatic void build_frame_bytes(etf_pkg::func_t op, logic [7:0] d);
		logic [7:0]  c_byte;
		logic [7:0]  nb;
		logic [12:0] padded;
		case (op)
			etf_pkg::FUNC_START: begin
				for (int i = 0; i < 7; i++) begin
					queue_result(etf_pkg::PRE_BYTE, 12'(i), 1'b0, '0, 1'b0);
				end
				queue_result(etf_pkg::SFD_BYTE, 12'd7, 1'b0, '0, 1'b0);
				model_crc = etf_pkg::CRC_INIT;
				model_len = '0;
				model_open = 1'b1;
			end
			etf_pkg::FUNC_DATA: begin
				if (!model_open || model_len >= etf_pkg::MAX_FRAME) begin
					queue_result('0, '0, 1'b0, '0, 1'b1);
				end else begin
					queue_result({d[3:0], d[7:4]}, model_len + etf_pkg::HDR_LEN,
						1'b0, '0, 1'b0);
					model_crc = crc_step(model_crc, d);
					model_len = model_len + 12'd1;
				end
			end
			etf_pkg::FUNC_END: begin
				if (!model_open) begin
					queue_result('0, '0, 1'b0, '0, 1'b1);
				end else begin
					while (model_len < etf_pkg::MIN_LEN || model_len[1:0] != 2'b00) begin
						queue_result(8'h00, model_len + etf_pkg::HDR_LEN, 1'b0, '0, 1'b0);
						model_crc = crc_step(model_crc, 8'h00);
						model_len = model_len + 12'd1;
					end
					padded = {1'b0, model_len} + 13'd16;
					for (int i = 0; i < 4; i++) begin
						c_byte = model_crc[31 - 8 * i -: 8];
						nb = ~c_byte;
						queue_result(
							{nb[4], nb[5], nb[6], nb[7], nb[0], nb[1], nb[2], nb[3]},
							model_len + etf_pkg::HDR_LEN + 12'(i), i == 3,
							(i == 3) ? 10'(padded >> 2) : 10'd0, 1'b0);
					end
					model_open = 1'b0;
				end
			end
			default: begin
				queue_result('0, '0, 1'b0, '0, 1'b1);
			end
		endcase
	endfunction

	function automatic void report_mismatch(string what, frame_result_t want,
			frame_result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%t %s: expected byte %h off %0d last %b words %0d err %b",
				$realtime, what, want.val, want.offset, want.last, want.words, want.err);
			$display("    got byte %h off %0d last %b words %0d err %b",
				got.val, got.offset, got.last, got.words, got.err);
		end
	endfunction

	// driver: presents queued transactions, holds payload while stalled
	always @(posedge clk or negedge arst_n) begin
		tx_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending_items.size() == 0) begin
				in_valid <= 1'b0;
			end else if (pending_items[0].hold) begin
				// pause the sender until the block has drained
				in_valid <= 1'b0;
				if (!in_valid && frame_bytes_due.size() == 0) begin
					void'(pending_items.pop_front());
				end
			end else if ($urandom_range(99) < pending_items[0].gap_pct) begin
				in_valid <= 1'b0;
			end else begin
				nxt = pending_items.pop_front();
				in_valid <= 1'b1;
				func <= nxt.op;
				data_byte <= nxt.data;
				cur_stall_pct <= nxt.stall_pct;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < cur_stall_pct);
		end
	end

	// monitor: predicts on each accepted input, then checks each accepted result
	always @(posedge clk) begin
		frame_result_t got;
		frame_result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				items_taken++;
				build_frame_bytes(etf_pkg::func_t'(func), data_byte);
			end
			if (out_valid && !out_stall) begin
				got.val = out_byte;
				got.offset = byte_offset;
				got.last = last;
				got.words = word_count;
				got.err = error;
				results_checked++;
				if (got.last) frames_closed++;
				if (got.err) error_results++;
				if (frame_bytes_due.size() == 0) begin
					report_mismatch("unexpected result", '0, got);
				end else begin
					want = frame_bytes_due.pop_front();
					if (got.val != want.val || got.offset != want.offset ||
							got.last != want.last || got.words != want.words ||
							got.err != want.err) begin
						report_mismatch("mismatch", want, got);
					end
				end
			end
		end
	end

	task automatic add_item(etf_pkg::func_t op, logic [7:0] d);
		tx_item_t it;
		it.op = op;
		it.data = d;
		it.hold = 1'b0;
		it.gap_pct = fill_gap_pct;
		it.stall_pct = fill_stall_pct;
		pending_items.push_back(it);
	endtask

	task automatic begin_phase(int unsigned gap, int unsigned stall);
		tx_item_t it;
		it.op = etf_pkg::FUNC_START;
		it.data = '0;
		it.hold = 1'b1;
		it.gap_pct = gap;
		it.stall_pct = stall;
		pending_items.push_back(it);
		fill_gap_pct = gap;
		fill_stall_pct = stall;
	endtask

	task automatic add_random_phase(int unsigned gap, int unsigned stall, int count);
		int added;
		int n;
		int r;
		added = 0;
		begin_phase(gap, stall);
		while (added < count) begin
			r = $urandom_range(99);
			if (r < 75) begin
				// well-formed frame, mostly short, now and then near the pad limit
				n = ($urandom_range(9) == 0) ? $urandom_range(66, 55) : $urandom_range(12);
				add_item(etf_pkg::FUNC_START, 8'($urandom));
				for (int i = 0; i < n; i++) begin
					add_item(etf_pkg::FUNC_DATA, 8'($urandom));
				end
				add_item(etf_pkg::FUNC_END, 8'($urandom));
				added += n + 2;
			end else if (r < 88) begin
				add_item(etf_pkg::func_t'($urandom_range(3)), 8'($urandom));
				added++;
			end else begin
				// broken frame: restarted or interrupted by an illegal code
				add_item(etf_pkg::FUNC_START, 8'($urandom));
				n = $urandom_range(5);
				for (int i = 0; i < n; i++) begin
					add_item(etf_pkg::FUNC_DATA, 8'($urandom));
				end
				add_item($urandom_range(1) ? etf_pkg::FUNC_START : etf_pkg::FUNC_BAD,
					8'($urandom));
				added += n + 2;
			end
		end
	endtask

	initial begin
		// directed: errors without a frame, payload extremes, restart, empty frame
		add_item(etf_pkg::FUNC_END, 8'h00);
		add_item(etf_pkg::FUNC_DATA, 8'hff);
		add_item(etf_pkg::FUNC_BAD, 8'hff);
		add_item(etf_pkg::FUNC_START, 8'h00);
		add_item(etf_pkg::FUNC_DATA, 8'h00);
		add_item(etf_pkg::FUNC_DATA, 8'hff);
		add_item(etf_pkg::FUNC_DATA, 8'ha5);
		add_item(etf_pkg::FUNC_DATA, 8'h5a);
		add_item(etf_pkg::FUNC_BAD, 8'h00);
		add_item(etf_pkg::FUNC_END, 8'hff);
		add_item(etf_pkg::FUNC_DATA, 8'h12);
		add_item(etf_pkg::FUNC_END, 8'h00);
		add_item(etf_pkg::FUNC_START, 8'hff);
		add_item(etf_pkg::FUNC_START, 8'h00);
		add_item(etf_pkg::FUNC_END, 8'h00);
		add_item(etf_pkg::FUNC_START, 8'h00);
		add_item(etf_pkg::FUNC_DATA, 8'h01);
		add_item(etf_pkg::FUNC_DATA, 8'h80);
		add_item(etf_pkg::FUNC_END, 8'h00);

		add_random_phase(64, 0, 28);
		add_random_phase(0, 64, 28);
		add_random_phase(17, 17, 28);
		add_random_phase(0, 0, 28);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || in_valid || frame_bytes_due.size() != 0) begin
			@(posedge clk);
		end
		// catch any stray results
		repeat (100) @(posedge clk);

		$display("%0d transactions driven, %0d results checked, %0d frames closed, %0d errors",
			items_taken, results_checked, frames_closed, error_results);
		$display("covered stray and illegal codes, restarts, empty and padded frames");
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/etf_pkg.sv
rtl/etf_front.sv
rtl/etf_queue.sv
rtl/etf_back.sv
rtl/ethernet_tx_framer_crc32_top.sv
sim/ethernet_tx_framer_crc32_top_test.sv
